// ===== hdl/reaf_pkg.sv =====
// Shared types and constants of the other-network station table.
// Used by the channel interfaces, the slot cell and the top level.
package reaf_pkg;

   // Field widths fixed by the request and response formats.
   localparam int CMD_W  = 2;
   localparam int VAR_W  = 4;
   localparam int PI_W   = 16;
   localparam int AF_W   = 8;
   localparam int SLOT_W = 3;
   localparam int POS_W  = 2;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_GROUP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // Group variants that carry frequencies.
   localparam logic [VAR_W-1:0] VAR_BOTH_AF = 4'd4;
   localparam logic [VAR_W-1:0] VAR_LAST_AF = 4'd8;

   // Highest usable frequency code and the code that marks an empty entry.
   localparam logic [AF_W-1:0] AF_MAX_VALID = 8'd204;
   localparam logic [AF_W-1:0] AF_FILLER    = 8'd205;

   // Captured request.
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [VAR_W-1:0]  variant;
      logic [PI_W-1:0]   pi_code;
      logic [AF_W-1:0]   af_first;
      logic [AF_W-1:0]   af_second;
      logic              updates_frozen;
      logic [SLOT_W-1:0] read_slot;
      logic [POS_W-1:0]  read_position;
   } req_type;

   // Search token that walks the row of slot cells, one cell per cycle.
   typedef struct packed {
      logic              live;
      logic              stop;
      logic              found;
      logic              free_found;
      logic [SLOT_W-1:0] slot;
      logic [PI_W-1:0]   pi;
      logic [SLOT_W-1:0] rd_slot;
      logic [POS_W-1:0]  rd_pos;
      logic              rd_valid;
      logic [AF_W-1:0]   rd_af;
   } tok_type;

   // Update operations broadcast to the cells.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_CLAIM,
      OP_INSERT
   } op_kind_type;

   typedef struct packed {
      op_kind_type     kind;
      logic            to_zero;
      logic [PI_W-1:0] pi;
      logic [AF_W-1:0] freq;
   } op_type;

endpackage

// ===== hdl/reaf_ifs.sv =====
// Valid/ready channel interfaces for requests and responses of the station table.
// Depends on reaf_pkg for the field widths.
interface reaf_req_if import reaf_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [VAR_W-1:0]  variant;
   logic [PI_W-1:0]   pi_code;
   logic [AF_W-1:0]   af_first;
   logic [AF_W-1:0]   af_second;
   logic              updates_frozen;
   logic [SLOT_W-1:0] read_slot;
   logic [POS_W-1:0]  read_position;

   modport source (
      output valid, command, variant, pi_code, af_first, af_second,
             updates_frozen, read_slot, read_position,
      input  ready
   );
   modport sink (
      input  valid, command, variant, pi_code, af_first, af_second,
             updates_frozen, read_slot, read_position,
      output ready
   );
endinterface

interface reaf_rsp_if import reaf_pkg::*;;
   logic              valid;
   logic              ready;
   logic              found;
   logic [SLOT_W-1:0] slot;
   logic              new_entry;
   logic [AF_W-1:0]   af_value;

   modport source (
      output valid, found, slot, new_entry, af_value,
      input  ready
   );
   modport sink (
      input  valid, found, slot, new_entry, af_value,
      output ready
   );
endinterface

// ===== hdl/reaf_cell.sv =====
// One slot of the station table: valid bit, PI code and frequency list.
// Passes the search token on each cycle and applies broadcast updates. Uses reaf_pkg.
module reaf_cell import reaf_pkg::*; #(
   parameter int AF_PER_SLOT = 4,
   parameter int INDEX       = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  tok_type tok_in,
   output tok_type tok_out,
   input  op_type  op,
   output logic    selected
);

   logic            valid_ff, valid_in;
   logic            sel_ff, sel_in;
   logic            live_ff;
   tok_type         tok_ff, tok_in_next;
   logic [PI_W-1:0] pi_ff, pi_in;
   logic [AF_W-1:0] list_ff [AF_PER_SLOT];
   logic [AF_W-1:0] list_in [AF_PER_SLOT];
   logic [AF_W-1:0] ins_list [AF_PER_SLOT];
   logic            targeted;
   logic            pi_match;
   logic            ins_skip;

   assign targeted = op.to_zero ? (INDEX == 0) : sel_ff;
   assign pi_match = valid_ff && (pi_ff == tok_in.pi);
   assign selected = sel_ff;

   // Token processing: first free or matching slot stops the search.
   always_comb begin
      tok_in_next = tok_in;
      if (!tok_in.stop) begin
         if (!valid_ff) begin
            tok_in_next.stop       = 1'b1;
            tok_in_next.free_found = 1'b1;
            tok_in_next.slot       = SLOT_W'(INDEX);
         end else if (pi_ff == tok_in.pi) begin
            tok_in_next.stop  = 1'b1;
            tok_in_next.found = 1'b1;
            tok_in_next.slot  = SLOT_W'(INDEX);
         end
      end
      if (32'(tok_in.rd_slot) == INDEX) begin
         tok_in_next.rd_valid = valid_ff;
         tok_in_next.rd_af    = '0;
         for (int k = 0; k < AF_PER_SLOT; k++) begin
            if (valid_ff && (32'(tok_in.rd_pos) == k)) begin
               tok_in_next.rd_af = list_ff[k];
            end
         end
      end
   end

   // Front insertion: stop at a duplicate or the first empty entry; codes above AF_MAX_VALID are skipped.
   always_comb begin
      int  pos;
      logic done;
      pos      = AF_PER_SLOT - 1;
      done     = 1'b0;
      ins_skip = (op.freq > AF_MAX_VALID);
      for (int k = 0; k < AF_PER_SLOT; k++) begin
         if (!done) begin
            if (list_ff[k] == op.freq) begin
               ins_skip = 1'b1;
               done     = 1'b1;
            end else if (list_ff[k] == AF_FILLER) begin
               pos  = k;
               done = 1'b1;
            end
         end
      end
      for (int k = 0; k < AF_PER_SLOT; k++) begin
         if (k == 0) begin
            ins_list[k] = op.freq;
         end else if (k <= pos) begin
            ins_list[k] = list_ff[k-1];
         end else begin
            ins_list[k] = list_ff[k];
         end
      end
   end

   // Next slot contents and selection flag.
   always_comb begin
      valid_in = valid_ff;
      pi_in    = pi_ff;
      list_in  = list_ff;
      sel_in   = sel_ff;
      if (tok_in.live) begin
         sel_in = !tok_in.stop && (!valid_ff || pi_match);
      end else if (op.kind == OP_CLAIM) begin
         sel_in = targeted;
      end
      if (op.kind == OP_CLAIM && targeted) begin
         valid_in = 1'b1;
         pi_in    = op.pi;
         for (int k = 0; k < AF_PER_SLOT; k++) begin
            list_in[k] = AF_FILLER;
         end
      end else if (op.kind == OP_INSERT && targeted && !ins_skip) begin
         list_in = ins_list;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
         live_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
         live_ff  <= tok_in.live;
      end
   end

   // Slot payload and token payload.
   always_ff @(posedge clock) begin
      pi_ff   <= pi_in;
      list_ff <= list_in;
      tok_ff  <= tok_in_next;
   end

   always_comb begin
      tok_out      = tok_ff;
      tok_out.live = live_ff;
   end

endmodule

// ===== hdl/rds_eon_pi_af_table_unit.sv =====
// Top level of the other-network station table with alternative-frequency lists.
// Depends on reaf_pkg, reaf_ifs (channels) and reaf_cell (one cell per slot).
//
// Usage:
//   req_chan carries one request per valid/ready handshake: a group command
//   (PI plus two frequency bytes), a PI lookup, or a read of one list entry.
//   rsp_chan returns exactly one response per request, in order.
//   A request enters a row of SLOTS cells as a search token that moves one
//   cell per cycle; the token settles the matching or first free slot and
//   picks up the read entry. An active group command (not frozen, variant
//   VAR_BOTH_AF to VAR_LAST_AF) then claims a new slot if its PI was not
//   found, and inserts the first frequency byte (VAR_BOTH_AF only) and
//   then the second. One request is in flight at a time, so a new request
//   is accepted only once the previous result is in the response register.
//   The response sits in an output register, so the next request is taken
//   and processed while the receiver stalls; only its completion waits.
//   Synchronous reset clears every slot's valid bit and all handshake state.
module rds_eon_pi_af_table_unit import reaf_pkg::*; #(
   parameter int SLOTS       = 8,
   parameter int AF_PER_SLOT = 4
) (
   input  logic       clock,
   input  logic       reset,
   reaf_req_if.sink   req_chan,
   reaf_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_CLAIM,
      S_INS_FIRST,
      S_INS_SECOND,
      S_FINISH
   } state_type;

   state_type         state_ff;
   req_type           req_ff;
   tok_type           chain [SLOTS+1];
   tok_type           tail;
   op_type            op;
   logic [SLOTS-1:0]  sel_vec;
   logic              req_accept;
   logic              rsp_load;
   logic              group_active;
   logic              res_found_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              res_new_ff;
   logic [AF_W-1:0]   res_af_ff;
   logic              to_zero_ff;
   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_new_ff;
   logic [AF_W-1:0]   rsp_af_ff;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign tail           = chain[SLOTS];
   assign group_active   = (req_ff.command == CMD_GROUP) && !req_ff.updates_frozen &&
                           (req_ff.variant >= VAR_BOTH_AF) && (req_ff.variant <= VAR_LAST_AF);

   // Search token injected at the head of the row when a request is accepted.
   always_comb begin
      chain[0]            = '0;
      chain[0].live       = req_accept;
      chain[0].pi         = req_chan.pi_code;
      chain[0].rd_slot    = req_chan.read_slot;
      chain[0].rd_pos     = req_chan.read_position;
   end

   // Update broadcast to the cells.
   always_comb begin
      op         = '0;
      op.kind    = OP_NONE;
      op.pi      = req_ff.pi_code;
      op.to_zero = 1'b0;
      op.freq    = req_ff.af_second;
      case (state_ff)
         S_CLAIM: begin
            op.kind    = OP_CLAIM;
            op.to_zero = to_zero_ff;
         end
         S_INS_FIRST: begin
            op.kind = OP_INSERT;
            op.freq = req_ff.af_first;
         end
         S_INS_SECOND: begin
            op.kind = OP_INSERT;
         end
         default: begin
            op.kind = OP_NONE;
         end
      endcase
   end

   // Row of slot cells.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      reaf_cell #(
         .AF_PER_SLOT (AF_PER_SLOT),
         .INDEX       (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1]),
         .op       (op),
         .selected (sel_vec[i])
      );
   end

   // Sequencer with result and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The response register fills on completion and empties once taken.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  req_ff.command        <= req_chan.command;
                  req_ff.variant        <= req_chan.variant;
                  req_ff.pi_code        <= req_chan.pi_code;
                  req_ff.af_first       <= req_chan.af_first;
                  req_ff.af_second      <= req_chan.af_second;
                  req_ff.updates_frozen <= req_chan.updates_frozen;
                  req_ff.read_slot      <= req_chan.read_slot;
                  req_ff.read_position  <= req_chan.read_position;
                  state_ff              <= S_WALK;
               end
            end
            S_WALK: begin
               if (tail.live) begin
                  case (req_ff.command) inside
                     CMD_GROUP, CMD_LOOKUP: begin
                        res_found_ff <= tail.found;
                        res_af_ff    <= '0;
                        if (group_active && !tail.found) begin
                           res_new_ff  <= 1'b1;
                           res_slot_ff <= tail.free_found ? tail.slot : '0;
                           to_zero_ff  <= !tail.free_found;
                           state_ff    <= S_CLAIM;
                        end else begin
                           res_new_ff  <= 1'b0;
                           res_slot_ff <= tail.found ? tail.slot : '0;
                           to_zero_ff  <= 1'b0;
                           if (!group_active) begin
                              state_ff <= S_FINISH;
                           end else if (req_ff.variant == VAR_BOTH_AF) begin
                              state_ff <= S_INS_FIRST;
                           end else begin
                              state_ff <= S_INS_SECOND;
                           end
                        end
                     end
                     CMD_READ: begin
                        res_found_ff <= tail.rd_valid;
                        res_slot_ff  <= req_ff.read_slot;
                        res_new_ff   <= 1'b0;
                        res_af_ff    <= tail.rd_af;
                        to_zero_ff   <= 1'b0;
                        state_ff     <= S_FINISH;
                     end
                     default: begin
                        res_found_ff <= 1'b0;
                        res_slot_ff  <= '0;
                        res_new_ff   <= 1'b0;
                        res_af_ff    <= '0;
                        to_zero_ff   <= 1'b0;
                        state_ff     <= S_FINISH;
                     end
                  endcase
               end
            end
            S_CLAIM: begin
               state_ff <= (req_ff.variant == VAR_BOTH_AF) ? S_INS_FIRST : S_INS_SECOND;
            end
            S_INS_FIRST: begin
               state_ff <= S_INS_SECOND;
            end
            S_INS_SECOND: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (rsp_load) begin
                  rsp_found_ff <= res_found_ff;
                  rsp_slot_ff  <= res_slot_ff;
                  rsp_new_ff   <= res_new_ff;
                  rsp_af_ff    <= res_af_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.slot      = rsp_slot_ff;
   assign rsp_chan.new_entry = rsp_new_ff;
   assign rsp_chan.af_value  = rsp_af_ff;

   // The token only leaves the row while the sequencer waits for it.
   a_tail_in_walk: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> (state_ff == S_WALK))
      else $error("search token left the row outside the walk");

   // Outside the walk at most one cell is selected for updates; during the walk
   // cells the token has not reached yet still hold the previous selection.
   a_one_selected: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WALK) |-> $onehot0(sel_vec))
      else $error("more than one slot selected");

   // A new slot is only claimed by an active group command.
   a_new_from_group: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_new_ff) |->
         ((req_ff.command == CMD_GROUP) && !req_ff.updates_frozen))
      else $error("new entry reported for a request that cannot claim a slot");

   // Only read requests report a frequency byte.
   a_af_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (res_af_ff != '0)) |-> (req_ff.command == CMD_READ))
      else $error("frequency byte reported for a non-read request");

endmodule
